>>> rtl/rprt_pkg.sv
// Package: shared constants, types and codes of the received packet range tracker.
package rprt_pkg;

	localparam int MAX_RANGES = 64;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int PN_W       = 62;

	typedef logic [PN_W-1:0]  pn_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	// One stored range, both bounds inclusive
	typedef struct packed {
		pn_t low;
		pn_t high;
	} range_entry_t;

	// Result status codes
	localparam logic [1:0] ST_IGNORED = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_APPLIED = 2'd2;

	// Item actions
	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DECIDE,
		S_COPY,
		S_WRITE,
		S_FINRD,
		S_FINCAP,
		S_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic check;
		logic scan;
		logic decide;
		logic copy;
		logic write_one;
		logic fin_rd;
		logic fin_cap;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic below_floor;
		logic scan_done;
		logic dup;
		logic copy_done;
	} sts_t;

endpackage

>>> rtl/rprt_ifs.sv
// Interfaces: input item channel and result channel of the range tracker.
interface rprt_item_if;
	logic             valid;
	logic             ready;
	logic             action;
	rprt_pkg::pn_t    packet_number;

	modport source (output valid, output action, output packet_number, input ready);
	modport sink   (input valid, input action, input packet_number, output ready);
endinterface

interface rprt_result_if;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [6:0]       range_count;
	logic             dropped_oldest;
	rprt_pkg::pn_t    highest_end;

	modport source (output valid, output status, output range_count,
		output dropped_oldest, output highest_end, input ready);
	modport sink   (input valid, input status, input range_count,
		input dropped_oldest, input highest_end, output ready);
endinterface

>>> rtl/received_packet_range_tracker.sv
// Top level: received packet-number range tracker, controller plus datapath.
// Sequence: after the input is taken, check, scan the ranges, plan, shift ranges, write one entry,
// read and capture the highest end, then show the result; a duplicate goes from the plan straight
// to the result, and a number below the floor goes from the check straight to the result.
// Throughput: one transaction at a time; the next is taken the cycle after the result leaves.
// Reset clears the range count, floor and highest end; the table itself is not cleared.
module received_packet_range_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	rprt_item_if.sink            item,
	rprt_result_if.source        result
);

	rprt_pkg::cmd_t cmd;
	rprt_pkg::sts_t sts;

	rprt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rprt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_action    (item.action),
		.in_pn        (item.packet_number),
		.res_status   (result.status),
		.res_count    (result.range_count),
		.res_dropped  (result.dropped_oldest),
		.res_high_end (result.highest_end)
	);

endmodule

>>> rtl/rprt_dp.sv
// Datapath: range table memory, scan, shift engine and result registers.
module rprt_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rprt_pkg::cmd_t        cmd,
	output rprt_pkg::sts_t        sts,
	input  logic                  in_action,
	input  rprt_pkg::pn_t         in_pn,
	output logic [1:0]            res_status,
	output logic [6:0]            res_count,
	output logic                  res_dropped,
	output rprt_pkg::pn_t         res_high_end
);

	// Range table, one write and one registered read per cycle
	rprt_pkg::range_entry_t mem [rprt_pkg::MAX_RANGES];
	rprt_pkg::range_entry_t rdata_q;

	logic                   act_q;
	rprt_pkg::pn_t          pn_q;
	rprt_pkg::pn_t          floor_q;
	rprt_pkg::pn_t          hi_end_q;
	rprt_pkg::cnt_t         held_q;
	rprt_pkg::cnt_t         pos_q;
	logic                   rv_q;
	logic                   found_q;
	logic                   hit_q;
	rprt_pkg::range_entry_t prev_q;
	rprt_pkg::range_entry_t next_q;
	logic [1:0]             status_q;
	logic                   drop_q;

	// Shift engine
	rprt_pkg::cnt_t         src_q;
	rprt_pkg::cnt_t         wsrc_q;
	rprt_pkg::cnt_t         cp_cnt_q;
	rprt_pkg::cnt_t         cp_off_q;
	logic                   cp_up_q;
	logic                   cp_clamp_q;
	logic                   cv_q;

	// Pending single-entry write
	logic                   wr_pend_q;
	rprt_pkg::idx_t         wr_addr_q;
	rprt_pkg::range_entry_t wr_data_q;

	rprt_pkg::cnt_t         scan_addr;
	rprt_pkg::cnt_t         fin_addr;
	rprt_pkg::cnt_t         pos_p1;
	rprt_pkg::cnt_t         pos_m1;
	rprt_pkg::cnt_t         copy_dst;
	rprt_pkg::idx_t         rd_addr;
	logic                   we;
	rprt_pkg::idx_t         wa;
	rprt_pkg::range_entry_t wd;
	rprt_pkg::range_entry_t cp_data;
	logic                   ge;
	logic                   jl;
	logic                   jh;
	logic                   full;

	// Address and flag arithmetic
	always_comb begin
		scan_addr = pos_q + rprt_pkg::cnt_t'(rv_q);
		fin_addr  = held_q - rprt_pkg::cnt_t'(1);
		pos_p1    = pos_q + rprt_pkg::cnt_t'(1);
		pos_m1    = pos_q - rprt_pkg::cnt_t'(1);
		copy_dst  = cp_up_q ? wsrc_q + rprt_pkg::cnt_t'(1) : wsrc_q - cp_off_q;
		ge        = rdata_q.high >= pn_q;
		jl        = (pos_q != '0) && (({1'b0, prev_q.high} + 63'd1) == {1'b0, pn_q});
		jh        = found_q && ({1'b0, next_q.low} == ({1'b0, pn_q} + 63'd1));
		full      = held_q == rprt_pkg::cnt_t'(rprt_pkg::MAX_RANGES);
		cp_data      = rdata_q;
		if (cp_clamp_q && rdata_q.low < pn_q) begin
			cp_data.low = pn_q;
		end
	end

	// Read address select
	always_comb begin
		priority if (cmd.copy) begin
			rd_addr = src_q[rprt_pkg::IDX_W-1:0];
		end else if (cmd.fin_rd) begin
			rd_addr = fin_addr[rprt_pkg::IDX_W-1:0];
		end else begin
			rd_addr = scan_addr[rprt_pkg::IDX_W-1:0];
		end
	end

	// Write port select
	always_comb begin
		we = (cmd.copy && cv_q) || (cmd.write_one && wr_pend_q);
		wa = cmd.copy ? copy_dst[rprt_pkg::IDX_W-1:0] : wr_addr_q;
		wd = cmd.copy ? cp_data : wr_data_q;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// Status toward the controller
	always_comb begin
		sts.below_floor = pn_q < floor_q;
		sts.dup         = (act_q == rprt_pkg::ACT_RECORD) && hit_q;
		sts.copy_done   = (cp_cnt_q == '0) && !cv_q;
		sts.scan_done   = (!rv_q && pos_q == held_q) || (rv_q && (ge || pos_p1 == held_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q      <= rprt_pkg::ACT_RECORD;
			pn_q       <= '0;
			floor_q    <= '0;
			hi_end_q   <= '0;
			held_q     <= '0;
			pos_q      <= '0;
			rv_q       <= 1'b0;
			found_q    <= 1'b0;
			hit_q      <= 1'b0;
			prev_q     <= '0;
			next_q     <= '0;
			status_q   <= rprt_pkg::ST_IGNORED;
			drop_q     <= 1'b0;
			src_q      <= '0;
			wsrc_q     <= '0;
			cp_cnt_q   <= '0;
			cp_off_q   <= '0;
			cp_up_q    <= 1'b0;
			cp_clamp_q <= 1'b0;
			cv_q       <= 1'b0;
			wr_pend_q  <= 1'b0;
			wr_addr_q  <= '0;
			wr_data_q  <= '0;
		end else begin
			// Capture the transaction
			if (cmd.load) begin
				act_q     <= in_action;
				pn_q      <= in_pn;
				status_q  <= rprt_pkg::ST_IGNORED;
				drop_q    <= 1'b0;
				hit_q     <= 1'b0;
				found_q   <= 1'b0;
				pos_q     <= '0;
				rv_q      <= 1'b0;
				cv_q      <= 1'b0;
				cp_cnt_q  <= '0;
				wr_pend_q <= 1'b0;
			end
			// Raise the floor
			if (cmd.check && !sts.below_floor && act_q == rprt_pkg::ACT_DELETE) begin
				floor_q <= pn_q;
			end
			// Scan for the first range ending at or above the number
			if (cmd.scan) begin
				rv_q <= 1'b1;
				if (rv_q) begin
					if (ge) begin
						found_q <= 1'b1;
						hit_q   <= rdata_q.low <= pn_q;
						next_q  <= rdata_q;
					end else begin
						prev_q <= rdata_q;
						pos_q  <= pos_p1;
					end
				end
			end
			// Plan the table update
			if (cmd.decide) begin
				status_q   <= sts.dup ? rprt_pkg::ST_PRESENT : rprt_pkg::ST_APPLIED;
				cv_q       <= 1'b0;
				cp_up_q    <= 1'b0;
				cp_clamp_q <= 1'b0;
				cp_off_q   <= rprt_pkg::cnt_t'(1);
				if (act_q == rprt_pkg::ACT_DELETE) begin
					cp_clamp_q <= 1'b1;
					cp_off_q   <= pos_q;
					src_q      <= pos_q;
					cp_cnt_q   <= held_q - pos_q;
					held_q     <= held_q - pos_q;
				end else if (!hit_q) begin
					priority if (jl && jh) begin
						src_q     <= pos_p1;
						cp_cnt_q  <= held_q - pos_p1;
						wr_pend_q <= 1'b1;
						wr_addr_q <= pos_m1[rprt_pkg::IDX_W-1:0];
						wr_data_q <= '{low: prev_q.low, high: next_q.high};
						held_q    <= held_q - rprt_pkg::cnt_t'(1);
					end else if (jl) begin
						wr_pend_q <= 1'b1;
						wr_addr_q <= pos_m1[rprt_pkg::IDX_W-1:0];
						wr_data_q <= '{low: prev_q.low, high: pn_q};
					end else if (jh) begin
						wr_pend_q <= 1'b1;
						wr_addr_q <= pos_q[rprt_pkg::IDX_W-1:0];
						wr_data_q <= '{low: pn_q, high: next_q.high};
					end else if (!full) begin
						cp_up_q   <= 1'b1;
						src_q     <= fin_addr;
						cp_cnt_q  <= held_q - pos_q;
						wr_pend_q <= 1'b1;
						wr_addr_q <= pos_q[rprt_pkg::IDX_W-1:0];
						wr_data_q <= '{low: pn_q, high: pn_q};
						held_q    <= held_q + rprt_pkg::cnt_t'(1);
					end else begin
						// Full: the lowest range falls out
						drop_q <= 1'b1;
						if (pos_q != '0) begin
							src_q     <= rprt_pkg::cnt_t'(1);
							cp_cnt_q  <= pos_m1;
							wr_pend_q <= 1'b1;
							wr_addr_q <= pos_m1[rprt_pkg::IDX_W-1:0];
							wr_data_q <= '{low: pn_q, high: pn_q};
						end
					end
				end
			end
			// Shift engine: read one entry, write it in the next cycle
			if (cmd.copy) begin
				wsrc_q <= src_q;
				if (cp_cnt_q != '0) begin
					cv_q     <= 1'b1;
					src_q    <= cp_up_q ? src_q - rprt_pkg::cnt_t'(1)
						: src_q + rprt_pkg::cnt_t'(1);
					cp_cnt_q <= cp_cnt_q - rprt_pkg::cnt_t'(1);
				end else begin
					cv_q <= 1'b0;
				end
			end
			if (cmd.write_one) begin
				wr_pend_q <= 1'b0;
			end
			// Refresh end of the highest range
			if (cmd.fin_cap) begin
				hi_end_q <= (held_q != '0) ? rdata_q.high : '0;
			end
		end
	end

	assign res_status   = status_q;
	assign res_count    = 7'(held_q);
	assign res_dropped  = drop_q;
	assign res_high_end = hi_end_q;

endmodule

>>> rtl/rprt_ctrl.sv
// Controller: state machine sequencing check, scan, shift, write and result.
module rprt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output rprt_pkg::cmd_t cmd,
	input  rprt_pkg::sts_t sts
);

	rprt_pkg::state_t state_q;
	rprt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rprt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			rprt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = rprt_pkg::S_CHECK;
				end
			end
			rprt_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.below_floor ? rprt_pkg::S_OUT : rprt_pkg::S_SCAN;
			end
			rprt_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = rprt_pkg::S_DECIDE;
				end
			end
			rprt_pkg::S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.dup ? rprt_pkg::S_OUT : rprt_pkg::S_COPY;
			end
			rprt_pkg::S_COPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_done) begin
					state_d = rprt_pkg::S_WRITE;
				end
			end
			rprt_pkg::S_WRITE: begin
				cmd.write_one = 1'b1;
				state_d       = rprt_pkg::S_FINRD;
			end
			rprt_pkg::S_FINRD: begin
				cmd.fin_rd = 1'b1;
				state_d    = rprt_pkg::S_FINCAP;
			end
			rprt_pkg::S_FINCAP: begin
				cmd.fin_cap = 1'b1;
				state_d     = rprt_pkg::S_OUT;
			end
			rprt_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = rprt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rprt_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/rprt_checker.sv
// Checker: port-level assertions on the range tracker, bound to the top level.
module rprt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [1:0]    status,
	input logic [6:0]    range_count,
	input logic          dropped_oldest,
	input rprt_pkg::pn_t highest_end
);

	// Ignored transaction never evicts
	a_ignored_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rprt_pkg::ST_IGNORED |-> !dropped_oldest)
		else $error("ignored transaction reports an eviction");

	// Empty table shows zero highest end
	a_empty_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_count == 7'd0 |-> highest_end == '0)
		else $error("empty table with nonzero highest end");

	// One transaction in flight: no intake while a result is shown
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	// Stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(highest_end))
		else $error("stalled result changed");

endmodule

bind received_packet_range_tracker rprt_checker u_rprt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item.valid),
	.in_ready       (item.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.status         (result.status),
	.range_count    (result.range_count),
	.dropped_oldest (result.dropped_oldest),
	.highest_end    (result.highest_end)
);
